@@ rtl/core/mlac_pkg.sv @@
// ---------------------------------------------------------------------------
// mlac_pkg
// Shared constants, types and register indexes of the lagged autocovariance
// engine.
// ---------------------------------------------------------------------------
package mlac_pkg;

   localparam int DefMaxRows   = 8;
   localparam int DefMaxCols   = 8;
   localparam int DefMaxSlices = 64;

   localparam int SampleW = 16;
   localparam int AccW    = 48;
   localparam int EntryW  = 32;
   localparam int CsrW    = 7;
   localparam int CsrIdxW = 2;

   localparam logic [CsrIdxW-1:0] CsrRows   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrCols   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrSlices = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrLag    = 2'd3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Handshake between the sequencer and the shared divider.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

@@ rtl/core/mlac_div.sv @@
// ---------------------------------------------------------------------------
// mlac_div
// Restoring divider, one quotient bit per cycle. Signed dividend, positive
// divisor, quotient truncated toward zero.
// ---------------------------------------------------------------------------
module mlac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mlac_pkg::AccW-1:0] dividend,
   input  logic [15:0]               divisor,
   output mlac_pkg::div_ctrl_type    ctrl,
   output logic [mlac_pkg::AccW-1:0] quotient
);
   import mlac_pkg::*;

   localparam int CntW = $clog2(AccW + 1);

   logic [AccW-1:0] quo_ff, quo_in;
   logic [16:0]     rem_ff, rem_in;
   logic [15:0]     dvs_ff, dvs_in;
   logic            neg_ff, neg_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [17:0]     trial;

   // One shift-subtract step per cycle over the dividend magnitude.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         neg_in  = dividend[AccW-1];
         quo_in  = dividend[AccW-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntW'(AccW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[AccW-1]} - {2'b00, dvs_ff};
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[AccW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[AccW-1]};
            quo_in = {quo_ff[AccW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quo_in = ~quo_in + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quotient   = quo_ff;

endmodule

@@ rtl/core/matrix_lagged_autocovariance_top.sv @@
// ---------------------------------------------------------------------------
// matrix_lagged_autocovariance_top
// Loads a cube of Q8.8 samples and emits the lagged autocovariance matrix.
// ---------------------------------------------------------------------------
// Samples load at one word per cycle into a cube memory that has one write
// port and one registered read port. The word flagged tlast starts the walk.
// For each of rows*rows entries, one shared 16x16 multiplier accumulates
// cols*(slices-lag) products. The two samples of a product are read in
// alternate cycles. Each entry passes the read, multiply and accumulate
// stages, then a bit-serial divider scales the sum and flags done. The
// entry is then presented on rsp_. When the lag is not below the slice
// count, the entries are zeros and come out at one per cycle while
// rsp_tready is high. req_tready is low from the tlast word until the last
// entry is taken.
module matrix_lagged_autocovariance_top #(
   parameter int MAX_ROWS   = mlac_pkg::DefMaxRows,
   parameter int MAX_COLS   = mlac_pkg::DefMaxCols,
   parameter int MAX_SLICES = mlac_pkg::DefMaxSlices
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // sample_value[15:0], row_index[18:16], col_index[21:19],
   // slice_index[27:22], zero pad [31:28]
   input  logic [31:0]                 req_tdata,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // entry_value[31:0], out_row[34:32], out_col[37:35], zero pad [39:38]
   output logic [39:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   // lag_error
   output logic                        rsp_tuser,
   input  logic                        csr_we,
   input  logic [mlac_pkg::CsrIdxW-1:0] csr_index,
   input  logic [mlac_pkg::CsrW-1:0]   csr_wdata
);
   import mlac_pkg::*;

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SW    = $clog2(MAX_SLICES);
   localparam int AddrW = RW + CW + SW;
   localparam int Depth = MAX_ROWS * MAX_COLS * MAX_SLICES;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [3:0] rows_ff, cols_ff;
   logic [6:0] slices_ff;
   logic [5:0] lag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 4'd8;
         cols_ff   <= 4'd8;
         slices_ff <= 7'd64;
         lag_ff    <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            CsrRows:   rows_ff   <= csr_wdata[3:0];
            CsrCols:   cols_ff   <= csr_wdata[3:0];
            CsrSlices: slices_ff <= csr_wdata[6:0];
            CsrLag:    lag_ff    <= csr_wdata[5:0];
            default:   ;
         endcase
      end
   end

   // Clamped sizes.
   logic [RW:0]  nr;
   logic [CW:0]  nc;
   logic [SW:0]  ns;
   logic         err;
   logic [SW:0]  nt;
   always_comb begin
      nr = (rows_ff == 4'd0) ? (RW+1)'(1) :
           (32'(rows_ff) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_ff);
      nc = (cols_ff == 4'd0) ? (CW+1)'(1) :
           (32'(cols_ff) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_ff);
      ns = (slices_ff == 7'd0) ? (SW+1)'(1) :
           (32'(slices_ff) > MAX_SLICES) ? (SW+1)'(MAX_SLICES) : (SW+1)'(slices_ff);
      err = 32'(lag_ff) >= 32'(ns);
      nt  = ns - (SW+1)'(lag_ff);
   end

   // Input unpacking.
   logic [15:0] in_sample;
   logic [2:0]  in_row, in_col;
   logic [5:0]  in_slice;
   logic        in_ok, req_fire;
   assign in_sample = req_tdata[15:0];
   assign in_row    = req_tdata[18:16];
   assign in_col    = req_tdata[21:19];
   assign in_slice  = req_tdata[27:22];
   assign in_ok     = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS) &&
                      (32'(in_slice) < MAX_SLICES);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;

   // Walk counters: entry (i,j), product index (t,k), phase selects operand.
   logic [RW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic [SW-1:0] t_ff, t_in;
   logic          ph_ff, ph_in;
   logic          walk_ff, walk_in;
   logic          lastp_in;

   // Cube memory, one write and one read per cycle.
   logic signed [SampleW-1:0] cube_mem [Depth];
   logic signed [SampleW-1:0] rd_ff;
   logic [AddrW-1:0]          rd_addr;
   logic [SW-1:0]             rd_slice;
   logic [RW-1:0]             rd_row;
   assign rd_row   = ph_ff ? j_ff : i_ff;
   assign rd_slice = ph_ff ? (t_ff + SW'(lag_ff)) : t_ff;
   assign rd_addr  = {rd_slice, k_ff, rd_row};

   always_ff @(posedge clock) begin
      if (req_fire && in_ok) begin
         cube_mem[{in_slice[SW-1:0], in_col[CW-1:0], in_row[RW-1:0]}] <= in_sample;
      end
      rd_ff <= cube_mem[rd_addr];
   end

   // Operand pipe: A held, product registered, then accumulated.
   logic signed [SampleW-1:0]   a_ff;
   logic                        rv_ff, rph_ff, rlast_ff;
   logic signed [2*SampleW-1:0] prod_ff;
   logic                        pv_ff, plast_ff;
   logic signed [AccW-1:0]      acc_ff, acc_in;
   logic                        accd_ff;

   div_ctrl_type            dctl;
   logic [AccW-1:0]         quo;
   logic [15:0]             divisor;
   assign divisor = 16'(nc) * 16'(nt);

   mlac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accd_ff),
      .dividend (acc_ff),
      .divisor  (divisor),
      .ctrl     (dctl),
      .quotient (quo)
   );

   // Counter advance for the product walk and for the entry index of each taken result.
   always_comb begin
      i_in = i_ff; j_in = j_ff; k_in = k_ff; t_in = t_ff; ph_in = ph_ff;
      walk_in = walk_ff; lastp_in = 1'b0;
      if (walk_ff) begin
         ph_in = ~ph_ff;
         if (ph_ff) begin
            if (32'(k_ff) + 1 < 32'(nc)) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (32'(t_ff) + 1 < 32'(nt)) begin
                  t_in = t_ff + 1'b1;
               end else begin
                  t_in     = '0;
                  walk_in  = 1'b0;
                  lastp_in = 1'b1;
               end
            end
         end
      end
      if (state_ff == ST_EMIT && rsp_tready) begin
         if (32'(j_ff) + 1 < 32'(nr)) begin
            j_in = j_ff + 1'b1;
         end else begin
            j_in = '0;
            i_in = i_ff + 1'b1;
         end
         walk_in = !err && !(32'(i_ff) + 1 == 32'(nr) && 32'(j_ff) + 1 == 32'(nr));
      end
      if (req_fire && req_tlast) begin
         i_in = '0; j_in = '0; k_in = '0; t_in = '0; ph_in = 1'b0;
         walk_in = !err;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (req_fire && req_tlast) begin
         acc_in = '0;
      end else if (state_ff == ST_EMIT && rsp_tready) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + AccW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0; rv_ff <= 1'b0; pv_ff <= 1'b0;
         plast_ff <= 1'b0; rlast_ff <= 1'b0; accd_ff <= 1'b0;
         acc_ff <= '0; i_ff <= '0; j_ff <= '0; k_ff <= '0; t_ff <= '0;
         ph_ff <= 1'b0;
      end else begin
         walk_ff  <= walk_in;
         i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; t_ff <= t_in; ph_ff <= ph_in;
         rv_ff    <= walk_ff;
         rph_ff   <= ph_ff;
         rlast_ff <= lastp_in;
         pv_ff    <= rv_ff && rph_ff;
         plast_ff <= rlast_ff;
         accd_ff  <= plast_ff;
         acc_ff   <= acc_in;
      end
      if (rv_ff && !rph_ff) begin
         a_ff <= rd_ff;
      end
      prod_ff <= a_ff * rd_ff;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_fire && req_tlast) state_in = err ? ST_EMIT : ST_MAC;
         ST_MAC:   if (accd_ff) state_in = ST_DIV;
         ST_DRAIN: state_in = ST_DIV;
         ST_DIV:   if (dctl.done) state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_tready) begin
               if (32'(i_ff) + 1 == 32'(nr) && 32'(j_ff) + 1 == 32'(nr)) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = err ? ST_EMIT : ST_MAC;
               end
            end
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   // Result word; the quotient register holds until the next divide starts.
   logic [EntryW-1:0] entry;
   always_comb begin
      entry      = err ? '0 : quo[EntryW-1:0];
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tdata  = {2'b00, 3'(j_ff), 3'(i_ff), entry};
      rsp_tlast  = (32'(i_ff) + 1 == 32'(nr)) && (32'(j_ff) + 1 == 32'(nr));
      rsp_tuser  = err;
   end

endmodule

@@ rtl/core/mlac_checker.sv @@
// ---------------------------------------------------------------------------
// mlac_assertions
// Port-level checks of the lagged autocovariance engine.
// ---------------------------------------------------------------------------
module mlac_assertions (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);
   // No new word is taken while results are shown.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input open during output");

   // The tlast word closes the input.
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input open after last word");

   // A lag error result carries a zero entry.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero entry on lag error");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
endmodule

bind matrix_lagged_autocovariance_top mlac_assertions u_mlac_assertions (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

@@ verif/mlac_checker.sv @@
// ----------------------------------------------------------------------------
// mlac_checker
// Watches the sample, result and register ports of the lagged autocovariance
// engine, keeps its own copy of the cube and the registers, works out the
// result matrix whenever a cube is closed and compares every result word
// against it in order.
// ----------------------------------------------------------------------------
module mlac_checker
   import mlac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [39:0]         rsp_tdata,
   input  logic                rsp_tlast,
   input  logic                rsp_tuser,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrW-1:0]     csr_wdata,
   output int                  mismatches,
   output int                  entries_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [EntryW-1:0] value;
      logic [2:0]               row;
      logic [2:0]               col;
      logic                     last;
      logic                     lag_err;
   } entry_type;

   localparam int StoreDepth = DefMaxRows * DefMaxCols * DefMaxSlices;

   logic signed [SampleW-1:0] cube_copy [StoreDepth];
   logic [3:0] rows_reg;
   logic [3:0] cols_reg;
   logic [6:0] slices_reg;
   logic [5:0] lag_reg;
   entry_type  entry_queue [$];

   assign entries_pending = entry_queue.size();

   function automatic int clamp_to(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int cube_addr(int r, int c, int s);
      return (s * DefMaxCols + c) * DefMaxRows + r;
   endfunction

   // Work out the full result matrix of the current cube.
   task automatic predict_matrix();
      int        nr;
      int        nc;
      int        ns;
      int        lag;
      bit        lag_err;
      longint    acc;
      longint    divisor;
      longint    quot;
      entry_type e;
      nr      = clamp_to(rows_reg, DefMaxRows);
      nc      = clamp_to(cols_reg, DefMaxCols);
      ns      = clamp_to(slices_reg, DefMaxSlices);
      lag     = lag_reg;
      lag_err = (lag >= ns);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nr; j++) begin
            quot = 0;
            if (!lag_err) begin
               acc     = 0;
               divisor = nc * (ns - lag);
               for (int t = 0; t + lag < ns; t++) begin
                  for (int k = 0; k < nc; k++) begin
                     acc += longint'(cube_copy[cube_addr(i, k, t)]) *
                            longint'(cube_copy[cube_addr(j, k, t + lag)]);
                  end
               end
               quot = acc / divisor;
            end
            e.value   = quot[31:0];
            e.row     = i[2:0];
            e.col     = j[2:0];
            e.last    = (i == nr - 1) && (j == nr - 1);
            e.lag_err = lag_err;
            entry_queue.push_back(e);
         end
      end
   endtask

   // Track register writes, sample words and result words.
   always @(posedge clock) begin
      entry_type e;
      if (reset) begin
         rows_reg   <= 4'd8;
         cols_reg   <= 4'd8;
         slices_reg <= 7'd64;
         lag_reg    <= 6'd0;
         entry_queue.delete();
         mismatches <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrRows:   rows_reg   <= csr_wdata[3:0];
               CsrCols:   cols_reg   <= csr_wdata[3:0];
               CsrSlices: slices_reg <= csr_wdata[6:0];
               CsrLag:    lag_reg    <= csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            cube_copy[cube_addr(req_tdata[18:16], req_tdata[21:19], req_tdata[27:22])] =
               req_tdata[15:0];
            if (req_tlast) predict_matrix();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (entry_queue.size() == 0) begin
               $display("%0t: unexpected result word, actual value %0d row %0d col %0d",
                        $time, $signed(rsp_tdata[31:0]), rsp_tdata[34:32], rsp_tdata[37:35]);
               mismatches <= mismatches + 1;
            end else begin
               e = entry_queue.pop_front();
               if (rsp_tdata[31:0] !== e.value || rsp_tdata[34:32] !== e.row ||
                   rsp_tdata[37:35] !== e.col || rsp_tlast !== e.last ||
                   rsp_tuser !== e.lag_err || rsp_tdata[39:38] !== 2'b00) begin
                  $display("%0t: result mismatch, expected value %0d row %0d col %0d last %0b err %0b",
                           $time, e.value, e.row, e.col, e.last, e.lag_err);
                  $display("%0t:                  actual value %0d row %0d col %0d last %0b err %0b",
                           $time, $signed(rsp_tdata[31:0]), rsp_tdata[34:32],
                           rsp_tdata[37:35], rsp_tlast, rsp_tuser);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the lagged autocovariance engine: loads cubes of Q8.8 samples
// under many register settings, with random idling on both streams, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
   import mlac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StoreDepth = DefMaxRows * DefMaxCols * DefMaxSlices;
   localparam int IdleLimit  = 20000;
   localparam int HoldCycles = 3000;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [31:0]        req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [39:0]        rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]    csr_wdata;
   int                 mismatches;
   int                 entries_pending;

   bit written_map [StoreDepth];
   int words_sent;
   int cur_rows;
   int cur_cols;
   int cur_slices;
   int cur_lag;
   bit no_gaps;
   bit hold_off;

   matrix_lagged_autocovariance_top dut (.*);

   mlac_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run if no word moves for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= IdleLimit) begin
            $display("matrix_lagged_autocovariance_top verification failed");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_to(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Stop offering and wait until every expected result has come; waiting on a
   // clock edge first lets the checker book a cube whose closing word was just taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (entries_pending == 0);
   endtask

   task automatic send_word(int addr, logic [15:0] sample, bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, addr[11:6], addr[5:3], addr[2:0], sample};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      written_map[addr] = 1'b1;
      words_sent++;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Only touch the registers once the engine has drained.
   task automatic set_config(int r, int c, int s, int lag);
      wait_drained();
      repeat (10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CsrRows;
      csr_wdata <= CsrW'(r);
      @(posedge clock);
      csr_index <= CsrCols;
      csr_wdata <= CsrW'(c);
      @(posedge clock);
      csr_index <= CsrSlices;
      csr_wdata <= CsrW'(s);
      @(posedge clock);
      csr_index <= CsrLag;
      csr_wdata <= CsrW'(lag);
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_rows   = clamp_to(r, DefMaxRows);
      cur_cols   = clamp_to(c, DefMaxCols);
      cur_slices = clamp_to(s, DefMaxSlices);
      cur_lag    = lag;
   endtask

   // Load one cube: every entry the walk reads is written before the closing
   // word, with stray writes anywhere in the store mixed in.
   task automatic run_cube();
      int  plan [$];
      int  addr;
      bit  needed;
      bit  lag_err;
      int  close_addr;
      lag_err = (cur_lag >= cur_slices);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!lag_err) begin
         for (int s = 0; s < cur_slices; s++) begin
            needed = (s < cur_slices - cur_lag) || (s >= cur_lag);
            if (needed) begin
               for (int c = 0; c < cur_cols; c++) begin
                  for (int r = 0; r < cur_rows; r++) begin
                     addr = (s * DefMaxCols + c) * DefMaxRows + r;
                     if (!written_map[addr] || $urandom_range(0, 3) == 0)
                        plan.push_back(addr);
                  end
               end
            end
         end
         close_addr = (cur_lag * DefMaxCols + $urandom_range(0, cur_cols - 1)) * DefMaxRows +
                      $urandom_range(0, cur_rows - 1);
      end else begin
         close_addr = $urandom_range(0, StoreDepth - 1);
      end
      repeat ($urandom_range(0, 3))
         plan.insert($urandom_range(0, plan.size()), $urandom_range(0, StoreDepth - 1));
      foreach (plan[n]) send_word(plan[n], rand_sample(), 1'b0);
      send_word(close_addr, rand_sample(), 1'b1);
   endtask

   // Directed cases, then random cubes.
   initial begin
      int r;
      int c;
      int s;
      int lag;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CsrRows;
      csr_wdata  <= '0;
      words_sent = 0;
      no_gaps    = 1'b0;
      hold_off   = 1'b0;
      cur_rows = 8; cur_cols = 8; cur_slices = 64; cur_lag = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Largest negative samples squared, then a lag of one and a lag too large.
      set_config(1, 1, 2, 0);
      send_word(0, 16'h8000, 1'b0);
      send_word(64, 16'h8000, 1'b1);
      set_config(1, 1, 2, 1);
      send_word(64, 16'h7fff, 1'b1);
      set_config(1, 1, 2, 2);
      send_word(5, 16'h1234, 1'b1);
      // Registers beyond their range saturate; extreme lag against full depth.
      set_config(15, 0, 127, 63);
      run_cube();
      set_config(0, 15, 0, 0);
      run_cube();
      set_config(8, 1, 5, 63);
      run_cube();
      set_config(8, 8, 1, 0);
      run_cube();

      // Random settings, mostly small cubes.
      for (int n = 0; words_sent < 280; n++) begin
         r   = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
         c   = $urandom_range(1, 3);
         s   = $urandom_range(1, 6);
         lag = ($urandom_range(0, 5) == 0) ? $urandom_range(s, 63) : $urandom_range(0, s - 1);
         set_config(r, c, s, lag);
         // The held-off iteration keeps offering cubes so the input stalls.
         repeat ((n == 3) ? 3 : $urandom_range(1, 3)) begin
            if (n == 3 && !hold_off) hold_off = 1'b1;
            if (words_sent < 280 || n == 3) run_cube();
         end
         // Sender waits out every result once in a while.
         if (n % 5 == 0) begin
            wait_drained();
         end
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && entries_pending == 0)
         $display("matrix_lagged_autocovariance_top verification clean");
      else
         $display("matrix_lagged_autocovariance_top verification failed");
      $finish;
   end

endmodule
